// ===== rtl/hxs_pkg.sv =====
// hxs_pkg: shared constants and tables for the sphere mapping pipeline
// no dependencies
`default_nettype none
package hxs_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CORDIC_STEPS_DEF = 18;
  localparam int MAX_STEPS = 32;
  localparam longint KGAIN_INF = 64'd652032874;
  localparam longint KGAIN_COR = 64'd434688583;
  localparam longint PI4_Q30 = 64'd843314857;

  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] v;
    case (i)
      0: v = 34'sd843314856;
      1: v = 34'sd497837829;
      2: v = 34'sd263043836;
      3: v = 34'sd133525158;
      4: v = 34'sd67021686;
      5: v = 34'sd33543515;
      6: v = 34'sd16775850;
      7: v = 34'sd8388437;
      8: v = 34'sd4194282;
      9: v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524287;
      12: v = 34'sd262143;
      13: v = 34'sd131071;
      14: v = 34'sd65535;
      15: v = 34'sd32767;
      16: v = 34'sd16383;
      17: v = 34'sd8191;
      18: v = 34'sd4095;
      19: v = 34'sd2047;
      20: v = 34'sd1023;
      21: v = 34'sd511;
      22: v = 34'sd255;
      23: v = 34'sd127;
      24: v = 34'sd63;
      25: v = 34'sd31;
      26: v = 34'sd15;
      27: v = 34'sd7;
      28: v = 34'sd3;
      29: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/hxs_if.sv =====
// hxs_if: valid/ready channel with a generic payload
// depends on nothing
`default_nettype none
interface hxs_if #(parameter int W = 8) (input wire logic clk);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/hxs_div.sv =====
// hxs_div: pipelined restoring divider, one quotient bit per stage, round to nearest
// depends on nothing
`default_nettype none
module hxs_div #(
  parameter int NW = 40,
  parameter int DW = 20,
  parameter int TW = 8
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [TW-1:0] tag_in,
  output logic      [NW-1:0] quo,
  output logic      [TW-1:0] tag_out
);
  // stage k decides quotient bit NW-1-k
  logic [NW-1:0] q   [NW+1];
  logic [NW-1:0] n   [NW+1];
  logic [DW:0]   r   [NW+1];
  logic [DW-1:0] d   [NW+1];
  logic [TW-1:0] tg  [NW+1];
  assign q[0] = '0;
  assign n[0] = num;
  assign r[0] = '0;
  assign d[0] = den;
  assign tg[0] = tag_in;
  for (genvar k = 0; k < NW; k++) begin : g_st
    logic [DW+1:0] sh;
    logic [DW+1:0] df;
    assign sh = {r[k], n[k][NW-1-k]};
    assign df = sh - {2'b00, d[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        n[k+1] <= n[k];
        d[k+1] <= d[k];
        tg[k+1] <= tg[k];
        if (!df[DW+1]) begin
          r[k+1] <= df[DW:0];
          q[k+1] <= q[k] | (NW'(1) << (NW-1-k));
        end else begin
          r[k+1] <= sh[DW:0];
          q[k+1] <= q[k];
        end
      end
    end
  end
  // remainder >= den - rem rounds up (ties away)
  always_comb begin
    quo = q[NW];
    if ({r[NW], 1'b0} >= {2'b00, d[NW]}) quo = q[NW] + NW'(1);
    tag_out = tg[NW];
  end
endmodule
`default_nettype wire

// ===== rtl/hxs_sqrt.sv =====
// hxs_sqrt: pipelined integer square root, one result bit per stage
// depends on nothing
`default_nettype none
module hxs_sqrt #(
  parameter int RW = 17,
  parameter int TW = 8
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [2*RW-1:0] v,
  input  wire logic [TW-1:0]   tag_in,
  output logic      [RW-1:0]   root,
  output logic      [TW-1:0]   tag_out
);
  logic [2*RW-1:0] vv [RW+1];
  logic [RW+1:0]   rm [RW+1];
  logic [RW-1:0]   rt [RW+1];
  logic [TW-1:0]   tg [RW+1];
  assign vv[0] = v;
  assign rm[0] = '0;
  assign rt[0] = '0;
  assign tg[0] = tag_in;
  for (genvar k = 0; k < RW; k++) begin : g_st
    logic [RW+1:0] a;
    logic [RW+1:0] b;
    assign a = {rm[k][RW-1:0], vv[k][2*RW-1-2*k -: 2]};
    assign b = {rt[k], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        vv[k+1] <= vv[k];
        tg[k+1] <= tg[k];
        if (a >= b) begin
          rm[k+1] <= a - b;
          rt[k+1] <= {rt[k][RW-2:0], 1'b1};
        end else begin
          rm[k+1] <= a;
          rt[k+1] <= {rt[k][RW-2:0], 1'b0};
        end
      end
    end
  end
  assign root = rt[RW];
  assign tag_out = tg[RW];
endmodule
`default_nettype wire

// ===== rtl/hxs_cordic.sv =====
// hxs_cordic: unrolled rotation-mode cordic, one register stage per iteration
// depends on hxs_pkg
`default_nettype none
module hxs_cordic
  import hxs_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF,
  parameter int TW = 8
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [33:0] ang,
  input  wire logic [TW-1:0]      tag_in,
  output logic signed [33:0]      cx,
  output logic signed [33:0]      cy,
  output logic [TW-1:0]           tag_out
);
  localparam int NS = (STEPS > MAX_STEPS) ? MAX_STEPS : STEPS;
  localparam longint KSH = 2 * NS;
  localparam longint K0 = KGAIN_INF + ((KSH < 63) ? (KGAIN_COR >> KSH) : 64'd0);
  logic signed [33:0] x [NS+1];
  logic signed [33:0] y [NS+1];
  logic signed [33:0] a [NS+1];
  logic [TW-1:0]      tg [NS+1];
  assign x[0] = 34'(K0);
  assign y[0] = '0;
  assign a[0] = ang;
  assign tg[0] = tag_in;
  for (genvar i = 0; i < NS; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (en) begin
        tg[i+1] <= tg[i];
        if (!a[i][33]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          a[i+1] <= a[i] - atan_q30(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          a[i+1] <= a[i] + atan_q30(i);
        end
      end
    end
  end
  assign cx = x[NS];
  assign cy = y[NS];
  assign tag_out = tg[NS];
endmodule
`default_nettype wire

// ===== rtl/healpix_reference_to_sphere.sv =====
// healpix_reference_to_sphere: base-face point to unit sphere, fully pipelined
// depends on hxs_pkg, hxs_if, hxs_div, hxs_sqrt, hxs_cordic
// throughput: one point per cycle while the pipeline is not stalled
// every unit is unrolled into one register stage per step
// every stage advances when the output register is empty or being drained
// reset (synchronous, rst) clears the valid bits only; payload needs no reset
`default_nettype none
module healpix_reference_to_sphere
  import hxs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  hxs_if.sink      in_ch,
  hxs_if.source    out_ch
);
  localparam int F = FRAC_BITS;
  localparam int IW = F + 1;
  localparam int OW = F + 2;
  localparam int SW = F + 5;           // signed plane values
  localparam int NS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int DNW = 2 * F + 2;      // divider numerator width
  localparam int DDW = F + 2;          // divider denominator width
  // s1..s5, divider, s6, s7, root, cordic, s8, output register
  localparam int LAT = 5 + DNW + 2 + (F + 1) + NS + 2;
  localparam logic signed [SW-1:0] ONE = SW'(1) << F;
  // reciprocal of three, exact for operands below 2^(SW-1)
  localparam longint RECIP3 = ((longint'(1) << SW) + 2) / 3;

  // item fields riding alongside the arithmetic
  typedef struct packed {
    logic signed [OW-1:0] z;
    logic                 last;
  } side_t;
  localparam int SDW = $bits(side_t);

  function automatic logic [SW-1:0] div3(input logic [SW-1:0] x);
    logic [2*SW-1:0] pr;
    pr = (2*SW)'(x) * (2*SW)'(RECIP3);
    return SW'(pr >> SW);
  endfunction

  // common stall: all stages move together, output holds one result
  logic [LAT-1:0] vld;
  logic           en;
  assign en = !vld[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: decode and clamp
  logic [3:0]   tin;
  logic [IW-1:0] xin, ein;
  logic          lin;
  assign {tin, xin, ein, lin} = in_ch.data;

  logic signed [SW-1:0] s1_ox, s1_oy, s1_xi, s1_eta;
  logic s1_last;
  always_ff @(posedge clk) begin
    if (en) begin
      logic [1:0] ly;
      ly = (tin[3:2] > 2'd2) ? 2'd2 : tin[3:2];
      s1_oy <= SW'($signed({1'b0, ly})) - SW'(1);
      s1_ox <= SW'({tin[1:0], ~ly[0]});
      s1_xi <= (xin == '0) ? SW'(1) : (xin >= IW'(ONE)) ? ONE - SW'(1) : SW'(xin);
      s1_eta <= (ein == '0) ? SW'(1) : (ein >= IW'(ONE)) ? ONE - SW'(1) : SW'(ein);
      s1_last <= lin;
    end
  end

  // stage 2: plane coordinates
  logic signed [SW-1:0] s2_dy, s2_ady, s2_dxr, s2_ox;
  logic s2_last;
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [SW-1:0] dy;
      dy = (s1_oy <<< F) + s1_xi + s1_eta - ONE;
      s2_dy <= dy;
      s2_ady <= dy[SW-1] ? -dy : dy;
      s2_dxr <= s1_xi - s1_eta;
      s2_ox <= s1_ox;
      s2_last <= s1_last;
    end
  end

  // stage 3: band select, t and t squared
  logic s3_pol, s3_north, s3_last;
  logic signed [SW-1:0] s3_dy, s3_dxr, s3_ox, s3_t;
  logic [2*F+3:0] s3_tt;
  always_ff @(posedge clk) begin
    if (en) begin
      logic [SW-1:0] t;
      t = (ONE <<< 1) - s2_ady;
      s3_pol <= s2_ady > ONE;
      s3_north <= !s2_dy[SW-1];
      s3_dy <= s2_dy;
      s3_dxr <= s2_dxr;
      s3_ox <= s2_ox;
      s3_t <= t;
      s3_tt <= (2*F+4)'(t[F+1:0]) * (2*F+4)'(t[F+1:0]);
      s3_last <= s2_last;
    end
  end

  // stage 4: divisions by three by reciprocal multiplication
  logic s4_pol, s4_north, s4_last, s4_neg;
  logic signed [SW-1:0] s4_ox, s4_t, s4_zeq;
  logic [SW-1:0] s4_sq;
  logic [DNW-1:0] s4_num;
  always_ff @(posedge clk) begin
    if (en) begin
      logic [SW-1:0] m;
      logic [SW-1:0] q3;
      m = s3_dy[SW-1] ? SW'(-s3_dy) : SW'(s3_dy);
      // round(2m/3) = floor((2m+1)/3)
      q3 = div3((m << 1) + SW'(1));
      s4_zeq <= s3_dy[SW-1] ? -q3 : q3;
      // round(t^2/(3*ONE)) = floor(floor((t^2 + 3*ONE/2) / ONE) / 3)
      s4_sq <= div3(SW'((s3_tt + ((2*F+4)'(3) << (F - 1))) >> F));
      s4_neg <= s3_dxr[SW-1];
      s4_num <= DNW'(s3_dxr[SW-1] ? -s3_dxr : s3_dxr) << F;
      s4_pol <= s3_pol;
      s4_north <= s3_north;
      s4_ox <= s3_ox;
      s4_t <= s3_t;
      s4_last <= s3_last;
    end
  end

  // stage 5: z and clamp; division of the angle offset launched
  typedef struct packed {
    side_t                sd;
    logic                 pol;
    logic                 neg;
    logic signed [SW-1:0] ox;
    logic signed [SW-1:0] lin;
  } dtag_t;
  dtag_t s5_tag;
  logic [DNW-1:0] s5_num;
  logic [DDW-1:0] s5_den;
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [SW-1:0] z;
      z = !s4_pol ? s4_zeq : (s4_north ? ONE - s4_sq : s4_sq - ONE);
      if (z > ONE) z = ONE;
      if (z < -ONE) z = -ONE;
      s5_tag.sd.z <= OW'(z);
      s5_tag.sd.last <= s4_last;
      s5_tag.pol <= s4_pol;
      s5_tag.neg <= s4_neg;
      s5_tag.ox <= s4_ox;
      s5_tag.lin <= s4_neg ? -SW'(s4_num >> F) : SW'(s4_num >> F);
      s5_num <= s4_num;
      s5_den <= s4_pol ? DDW'(s4_t) : DDW'(1);
    end
  end

  logic [DNW-1:0] dq;
  dtag_t d_tag;
  hxs_div #(.NW(DNW), .DW(DDW), .TW($bits(dtag_t))) u_div (
    .clk, .en, .num(s5_num), .den(s5_den), .tag_in(s5_tag), .quo(dq), .tag_out(d_tag)
  );

  // stage 6: phi in units of pi/4, reduce to quadrant, angle in radians
  localparam int PW = F + 4;
  logic [1:0] s6_quad;
  logic signed [33:0] s6_ang;
  side_t s6_sd;
  logic [2*F+1:0] s6_zz;
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [SW-1:0] off;
      logic [PW-1:0] p;
      logic [F:0] rem;
      logic [F+31:0] prod;
      logic [F:0] za;
      off = d_tag.pol ? (d_tag.neg ? -SW'(dq) : SW'(dq)) : d_tag.lin;
      p = PW'((d_tag.ox <<< F) + off);
      rem = p[F:0];
      prod = (F+32)'(rem) * (F+32)'(PI4_Q30) + ((F+32)'(1) << (F-1));
      s6_quad <= p[F+2:F+1];
      s6_ang <= 34'(prod >> F);
      za = d_tag.sd.z[OW-1] ? (F+1)'(-d_tag.sd.z) : (F+1)'(d_tag.sd.z);
      s6_zz <= (2*F+2)'(za) * (2*F+2)'(za);
      s6_sd <= d_tag.sd;
    end
  end

  // square root of one minus z squared
  typedef struct packed {
    side_t      sd;
    logic [1:0] quad;
    logic signed [33:0] ang;
  } rtag_t;
  rtag_t s7_tag, r_tag;
  logic [2*F+1:0] s7_v;
  always_ff @(posedge clk) begin
    if (en) begin
      s7_v <= ((2*F+2)'(1) << (2*F)) - s6_zz;
      s7_tag <= '{sd: s6_sd, quad: s6_quad, ang: s6_ang};
    end
  end
  logic [F:0] root;
  hxs_sqrt #(.RW(F+1), .TW($bits(rtag_t))) u_sqrt (
    .clk, .en, .v(s7_v), .tag_in(s7_tag), .root, .tag_out(r_tag)
  );

  typedef struct packed {
    side_t      sd;
    logic [1:0] quad;
    logic [F:0] st;
  } ctag_t;
  ctag_t c_in, c_tag;
  assign c_in = '{sd: r_tag.sd, quad: r_tag.quad, st: root};
  logic signed [33:0] cx, cy;
  hxs_cordic #(.STEPS(NS), .TW($bits(ctag_t))) u_cordic (
    .clk, .en, .ang(r_tag.ang), .tag_in(c_in),
    .cx, .cy, .tag_out(c_tag)
  );

  // quadrant fold and scale by s
  logic signed [F+36:0] s8_px, s8_py;
  side_t s8_sd;
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [33:0] c, s;
      case (c_tag.quad)
        2'd0: begin c = cx; s = cy; end
        2'd1: begin c = -cy; s = cx; end
        2'd2: begin c = -cx; s = -cy; end
        default: begin c = cy; s = -cx; end
      endcase
      s8_px <= $signed({1'b0, c_tag.st}) * (F+37)'(c);
      s8_py <= $signed({1'b0, c_tag.st}) * (F+37)'(s);
      s8_sd <= c_tag.sd;
    end
  end

  function automatic logic [OW-1:0] fin(input logic signed [F+36:0] v);
    logic [F+36:0] m;
    logic signed [F+36:0] r;
    m = v[F+36] ? -v : v;
    m = (m + ((F+37)'(1) << 29)) >> 30;
    r = v[F+36] ? -$signed(m) : $signed(m);
    if (r > (F+37)'(ONE)) r = (F+37)'(ONE);
    if (r < -(F+37)'(ONE)) r = -(F+37)'(ONE);
    return OW'(r);
  endfunction

  // output register
  logic [OW-1:0] ox_r, oy_r;
  side_t osd;
  always_ff @(posedge clk) begin
    if (en) begin
      ox_r <= fin(s8_px);
      oy_r <= fin(s8_py);
      osd <= s8_sd;
    end
  end

  // valid bits travel with the data; the last one marks the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_ch.valid};
    end
  end
  assign out_ch.valid = vld[LAT-1];
  assign out_ch.data = {ox_r, oy_r, osd.z, osd.last};
endmodule
`default_nettype wire

// ===== rtl/hxs_checker.sv =====
// hxs_checker: port-level checks on the sphere mapping top level
// depends on the top level ports; bound below
`default_nettype none
module hxs_checker #(parameter int OW = 18) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [3*OW:0] out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready) else $error("ready");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid) else $error("rst");
endmodule
bind healpix_reference_to_sphere hxs_checker #(.OW(FRAC_BITS+2)) u_chk (
  .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire
